/* rtl/core/auxiliary_stack_sorter_assert.svh */
// assertion macros shared by the sorter rtl
// expects i_clk and i_rst_n in the scope of each use
`ifndef AUXILIARY_STACK_SORTER_ASSERT_SVH
`define AUXILIARY_STACK_SORTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define AUX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define AUX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/aux_sort_pkg.sv */
// shared types and constants for the stack sorter
// no dependencies
package aux_sort_pkg;

    localparam int DEPTH = 64;
    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic drain;
    } t_cell_ctl;

endpackage

/* rtl/core/aux_sort_cell.sv */
// one cell of the sorting chain: holds a value and its valid flag
// depends on aux_sort_pkg
module aux_sort_cell import aux_sort_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_data     i_value,
    input  t_data     i_prev_value,
    input  logic      i_prev_valid,
    input  logic      i_prev_take,
    input  t_data     i_next_value,
    input  logic      i_next_valid,
    output t_data     o_value,
    output logic      o_valid,
    output logic      o_take
);

    t_data r_value;
    logic  r_valid;
    t_data n_value;
    logic  n_valid;

    // the new value belongs here or further left
    assign o_take = !r_valid || (i_value < r_value);

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.drain) begin
            n_value = i_next_value;
            n_valid = i_next_valid;
        end else if (i_ctl.insert && o_take) begin
            // either the new value lands here or the left neighbour's value moves in
            if (i_prev_take) begin
                n_value = i_prev_value;
                n_valid = i_prev_valid;
            end else begin
                n_value = i_value;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

/* rtl/core/auxiliary_stack_sorter.sv */
// stack sorter top level: a chain of DEPTH cells kept in ascending order
// load: one input transaction per cycle, each value is placed into the chain at once
// sort costs nothing extra; draining starts the cycle after the last-marked input
// n results follow at one per cycle from the head cell, while i_out_ready holds high
// values beyond DEPTH are dropped; synchronous active-low reset empties every cell
// depends on aux_sort_pkg, aux_sort_cell and auxiliary_stack_sorter_assert.svh
`include "auxiliary_stack_sorter_assert.svh"

module auxiliary_stack_sorter import aux_sort_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_data i_value,
    input  logic  i_last,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_data o_value_res,
    output logic  o_last_res
);

    t_state    r_state;
    t_state    n_state;
    t_cell_ctl w_ctl;
    logic      w_in_fire;
    logic      w_out_fire;
    logic      w_full;

    t_data             w_value [DEPTH];
    logic [DEPTH-1:0]  w_valid;
    logic [DEPTH-1:0]  w_take;

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_fire = o_out_valid && i_out_ready;
    assign w_full     = w_valid[DEPTH-1];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_in_fire && i_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_out_fire && o_last_res) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_LOAD:  o_in_ready  = 1'b1;
            ST_DRAIN: o_out_valid = 1'b1;
            default: begin
                o_in_ready  = 1'b0;
                o_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // a full chain drops the incoming value
    assign w_ctl.insert = w_in_fire && !w_full;
    assign w_ctl.drain  = w_out_fire;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_data g_prev_value;
            logic  g_prev_valid;
            logic  g_prev_take;
            t_data g_next_value;
            logic  g_next_valid;

            if (g == 0) begin : g_head
                assign g_prev_value = '0;
                assign g_prev_valid = 1'b0;
                assign g_prev_take  = 1'b0;
            end else begin : g_body
                assign g_prev_value = w_value[g-1];
                assign g_prev_valid = w_valid[g-1];
                assign g_prev_take  = w_take[g-1];
            end

            if (g == DEPTH-1) begin : g_tail
                assign g_next_value = '0;
                assign g_next_valid = 1'b0;
            end else begin : g_mid
                assign g_next_value = w_value[g+1];
                assign g_next_valid = w_valid[g+1];
            end

            aux_sort_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_value      (i_value),
                .i_prev_value (g_prev_value),
                .i_prev_valid (g_prev_valid),
                .i_prev_take  (g_prev_take),
                .i_next_value (g_next_value),
                .i_next_valid (g_next_valid),
                .o_value      (w_value[g]),
                .o_valid      (w_valid[g]),
                .o_take       (w_take[g])
            );
        end
    endgenerate

    assign o_value_res = w_value[0];
    assign o_last_res  = !w_valid[1];

    `AUX_ASSERT_NOW(a_drain_has_head, r_state == ST_DRAIN, w_valid[0], "drain with empty head cell")
    `AUX_ASSERT_NOW(a_valid_packed, 1'b1, ((w_valid + 1'b1) & w_valid) == '0, "cells not packed")
    `AUX_ASSERT_NEXT(a_final_empties, w_out_fire && o_last_res, w_valid == '0, "chain not empty")
    `AUX_ASSERT_NEXT(a_insert_grows, w_ctl.insert && !w_ctl.drain,
        $countones(w_valid) == $countones($past(w_valid)) + 1, "insert did not add a cell")

endmodule

/* bench/sorter_result_checker.sv */
// result checker for the stack sorter: watches both channels and predicts every sorted value
// keeps its own copy of the two stacks; depends on aux_sort_pkg
`timescale 1ns / 100ps

module sorter_result_checker import aux_sort_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_ready,
    input  t_data i_value,
    input  logic  i_last,
    input  logic  i_out_valid,
    input  logic  i_out_ready,
    input  t_data i_value_res,
    input  logic  i_last_res,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct {
        t_data value;
        logic  last;
    } t_sorted;

    t_data   held [DEPTH];
    int      held_n;
    t_sorted sorted_q [$];
    t_sorted want;
    int      mismatches;

    // two-stack sort of the held set, then the holder is popped into the expected results
    task automatic sort_held_values();
        t_data   holder [DEPTH];
        int      holder_n;
        t_data   cur;
        t_sorted res;
        holder_n = 0;
        while (held_n > 0) begin
            cur = held[held_n-1];
            held_n--;
            while (holder_n > 0 && holder[holder_n-1] < cur) begin
                held[held_n] = holder[holder_n-1];
                held_n++;
                holder_n--;
            end
            holder[holder_n] = cur;
            holder_n++;
        end
        while (holder_n > 0) begin
            holder_n--;
            res.value = holder[holder_n];
            res.last  = (holder_n == 0);
            sorted_q.push_back(res);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_n = 0;
            mismatches = 0;
            sorted_q.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (sorted_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected transaction, value %0d last %0b",
                                 $time, i_value_res, i_last_res);
                end else begin
                    want = sorted_q.pop_front();
                    if (i_value_res !== want.value || i_last_res !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected %0d last %0b, got %0d last %0b",
                                     $time, want.value, want.last, i_value_res,
                                     i_last_res);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                // a full stack drops the value, but a last marker still starts the sort
                if (held_n < DEPTH) begin
                    held[held_n] = i_value;
                    held_n++;
                end
                if (i_last)
                    sort_held_values();
            end
            o_fail_count <= mismatches;
            o_pending <= sorted_q.size();
        end
    end

endmodule

/* bench/auxiliary_stack_sorter_tb.sv */
// testbench top for auxiliary_stack_sorter: drives sets of signed values and gives the verdict
// depends on aux_sort_pkg, the sorter rtl and sorter_result_checker
`timescale 1ns / 100ps

module auxiliary_stack_sorter_tb;
    import aux_sort_pkg::*;

    localparam t_data MAX_V = 32'sh7fff_ffff;
    localparam t_data MIN_V = 32'sh8000_0000;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    t_data i_value;
    logic  i_last;
    logic  o_out_valid;
    logic  i_out_ready;
    t_data o_value_res;
    logic  o_last_res;

    int fail_count;
    int pending;
    bit calm;
    // input transactions accepted so far
    int sent;

    auxiliary_stack_sorter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value_res (o_value_res),
        .o_last_res  (o_last_res)
    );

    sorter_result_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_value      (i_value),
        .i_last       (i_last),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_value_res  (o_value_res),
        .i_last_res   (o_last_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // mix of full-range values, a narrow band for duplicates and the extremes
    function automatic t_data pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2, 3, 4: return t_data'($urandom);
            5, 6: return t_data'($signed($urandom_range(0, 15)) - 8);
            7: return $urandom_range(0, 1) ? MAX_V : MIN_V;
            8: return $urandom_range(0, 1) ? MAX_V - t_data'($urandom_range(0, 3))
                                           : MIN_V + t_data'($urandom_range(0, 3));
            default: return t_data'($urandom_range(0, 1)) - 1;
        endcase
    endfunction

    task automatic push_item(input t_data v, input logic l);
        int gap;
        i_in_valid <= 1'b1;
        i_value <= v;
        i_last <= l;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic push_set(input t_data vals [$]);
        foreach (vals[i])
            push_item(vals[i], i == vals.size() - 1);
    endtask

    // hold the input back until every sorted value has been taken
    task automatic wait_sorted_out();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // result side: random back-pressure, none while calm
    initial begin
        int hold;
        hold = 0;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                hold--;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    hold = pick_gap();
            end
            @(posedge i_clk);
        end
    end

    initial begin
        int  size;
        bit  overflow_done;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_value <= '0;
        i_last <= 1'b0;
        calm = 1'b1;
        sent = 0;
        overflow_done = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-value sets: zero and the two extremes
        push_set('{t_data'(0)});
        push_set('{MAX_V});
        calm = 1'b0;
        push_set('{MIN_V});
        // signed ordering across the sign boundary, alternating bit patterns
        push_set('{MAX_V, MIN_V, t_data'(0), t_data'(-1), t_data'(1),
                   t_data'(32'h5555_5555), t_data'(32'haaaa_aaaa)});
        // equal values end up side by side
        push_set('{t_data'(5), t_data'(5), t_data'(-5), t_data'(5), t_data'(-5)});
        push_set('{t_data'(1), t_data'(2), t_data'(3), t_data'(4)});
        push_set('{t_data'(4), t_data'(3), t_data'(2), t_data'(1)});
        wait_sorted_out();

        while (sent < 110) begin
            if (!overflow_done && sent >= 30) begin
                // overfill the stack so that late values, the last one too, are dropped
                size = $urandom_range(DEPTH + 1, DEPTH + 4);
                overflow_done = 1'b1;
            end else if ($urandom_range(0, 9) < 7) begin
                size = $urandom_range(1, 4);
            end else begin
                size = $urandom_range(5, 12);
            end
            calm = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < size; i++)
                push_item(pick_value(), i == size - 1);
            if ($urandom_range(0, 4) == 0)
                wait_sorted_out();
        end

        wait_sorted_out();
        repeat (2 * DEPTH + 20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
